FILE: src/bda_pkg.sv
// Shared types, codes and helpers for the button debounce and auto-repeat block.
// No dependencies; every other file in src uses this package by scoped names.
`timescale 1ns / 1ps

package bda_pkg;

  // Timer and register width (time units)
  localparam int TIME_W    = 16;
  localparam int CFG_IDX_W = 2;

  typedef logic [TIME_W-1:0] time_t;

  // Register reset values
  localparam time_t DEBOUNCE_RST = time_t'(100);
  localparam time_t DELAY_RST    = time_t'(0);
  localparam time_t PERIOD_RST   = time_t'(100);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE_TIME = 2'd0,
    CFG_REPEAT_DELAY  = 2'd1,
    CFG_REPEAT_PERIOD = 2'd2
  } cfg_idx_e;

  // Item commands; the fourth code is unused and acts as a no-op
  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_e;

  // Latched event codes
  typedef enum logic [1:0] {
    EV_IDLE     = 2'd0,
    EV_PRESSED  = 2'd1,
    EV_RELEASED = 2'd2,
    EV_REPEAT   = 2'd3
  } event_e;

  // Hold phase, one-hot
  typedef enum logic [2:0] {
    PH_RELEASED = 3'b001,
    PH_PRESSED  = 3'b010,
    PH_REPEAT   = 3'b100
  } phase_e;

  typedef struct packed {
    logic [1:0] cmd;
    time_t      step_time;
    logic       level;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic       locked_out;
  } out_item_t;

  typedef struct packed {
    time_t debounce_time;
    time_t repeat_delay;
    time_t repeat_period;
  } cfg_t;

  // Input register contents
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

  // State visible to the top level
  typedef struct packed {
    logic   lock_active;
    event_e pend;
  } status_t;

  // Saturating add of two timer values
  function automatic time_t sat_add(time_t a, time_t b);
    logic [TIME_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  endfunction

endpackage

FILE: src/bda_cfg.sv
// Configuration registers: debounce time, repeat delay and repeat period.
// Depends on bda_pkg.
`timescale 1ns / 1ps

module bda_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bda_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  bda_pkg::time_t                 cfg_wdata_i,
  output bda_pkg::cfg_t                  cfg_o
);

  bda_pkg::cfg_t cfg_d, cfg_q;

  // Decode the write index; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        bda_pkg::CFG_DEBOUNCE_TIME: cfg_d.debounce_time = cfg_wdata_i;
        bda_pkg::CFG_REPEAT_DELAY:  cfg_d.repeat_delay  = cfg_wdata_i;
        bda_pkg::CFG_REPEAT_PERIOD: cfg_d.repeat_period = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_time <= bda_pkg::DEBOUNCE_RST;
      cfg_q.repeat_delay  <= bda_pkg::DELAY_RST;
      cfg_q.repeat_period <= bda_pkg::PERIOD_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: src/bda_in_stage.sv
// Input register: holds one accepted item until the core takes it.
// Depends on bda_pkg.
`timescale 1ns / 1ps

module bda_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  bda_pkg::in_item_t in_data_i,
  output logic              in_stall_o,
  input  logic              fire_i,
  output bda_pkg::stage_t   stage_o
);

  logic              valid_d, valid_q;
  bda_pkg::in_item_t item_q;
  logic              accept;

  // Stall only while a held item cannot move on
  assign in_stall_o = valid_q && !fire_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (fire_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.item  = item_q;

endmodule

FILE: src/bda_core.sv
// Debounce and auto-repeat state with its single-pass update per item.
// Depends on bda_pkg.
`timescale 1ns / 1ps

module bda_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  bda_pkg::in_item_t  item_i,
  input  bda_pkg::cfg_t      cfg_i,
  output bda_pkg::out_item_t res_o,
  output bda_pkg::status_t   status_o
);

  logic            lock_d, lock_q;
  bda_pkg::time_t  lock_el_d, lock_el_q;
  bda_pkg::time_t  rep_el_d, rep_el_q;
  bda_pkg::phase_e phase_d, phase_q;
  logic            level_d, level_q;
  bda_pkg::event_e pend_d, pend_q;

  bda_pkg::time_t  lock_sum;
  bda_pkg::time_t  rep_sum;
  logic            tick_reaches_rep;
  logic            rep_counting;

  assign lock_sum = bda_pkg::sat_add(lock_el_q, item_i.step_time);
  assign rep_sum  = bda_pkg::sat_add(rep_el_q, item_i.step_time);

  // Repeat timer runs only while held with repeat enabled
  assign rep_counting = level_q &&
                        (((phase_q == bda_pkg::PH_PRESSED) && (cfg_i.repeat_delay != '0)) ||
                         (phase_q == bda_pkg::PH_REPEAT));

  // Next state for the item in the input register
  always_comb begin
    lock_d           = lock_q;
    lock_el_d        = lock_el_q;
    rep_el_d         = rep_el_q;
    phase_d          = phase_q;
    level_d          = level_q;
    pend_d           = pend_q;
    tick_reaches_rep = 1'b0;

    case (item_i.cmd)
      bda_pkg::CMD_TICK: begin
        // Advance the lockout; its final tick also counts toward repeat
        if (lock_q) begin
          if (lock_sum >= cfg_i.debounce_time) begin
            lock_d           = 1'b0;
            lock_el_d        = '0;
            tick_reaches_rep = 1'b1;
          end else begin
            lock_el_d = lock_sum;
          end
        end else begin
          tick_reaches_rep = 1'b1;
        end
        if (tick_reaches_rep && rep_counting) begin
          rep_el_d = rep_sum;
        end
      end
      bda_pkg::CMD_SAMPLE: begin
        // Ignore samples during the lockout
        if (!lock_q) begin
          level_d = item_i.level;
          if (!item_i.level) begin
            if (phase_q != bda_pkg::PH_RELEASED) begin
              pend_d    = bda_pkg::EV_RELEASED;
              phase_d   = bda_pkg::PH_RELEASED;
              lock_d    = 1'b1;
              lock_el_d = '0;
              rep_el_d  = '0;
            end
          end else begin
            case (phase_q)
              bda_pkg::PH_RELEASED: begin
                pend_d    = bda_pkg::EV_PRESSED;
                phase_d   = bda_pkg::PH_PRESSED;
                lock_d    = 1'b1;
                lock_el_d = '0;
                rep_el_d  = '0;
              end
              bda_pkg::PH_PRESSED: begin
                if ((cfg_i.repeat_delay != '0) && (rep_el_q >= cfg_i.repeat_delay)) begin
                  pend_d   = bda_pkg::EV_REPEAT;
                  phase_d  = bda_pkg::PH_REPEAT;
                  rep_el_d = '0;
                end
              end
              bda_pkg::PH_REPEAT: begin
                if (rep_el_q >= cfg_i.repeat_period) begin
                  pend_d   = bda_pkg::EV_REPEAT;
                  rep_el_d = '0;
                end
              end
              default: ;
            endcase
          end
        end
      end
      bda_pkg::CMD_READ: begin
        // Clear the latched event once reported
        pend_d = bda_pkg::EV_IDLE;
      end
      default: ;
    endcase
  end

  // Report the event before a read clears it, otherwise after the update
  assign res_o.event_res  = (item_i.cmd == bda_pkg::CMD_READ) ? pend_q : pend_d;
  assign res_o.locked_out = lock_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_q    <= 1'b0;
      lock_el_q <= '0;
      rep_el_q  <= '0;
      phase_q   <= bda_pkg::PH_RELEASED;
      level_q   <= 1'b0;
      pend_q    <= bda_pkg::EV_IDLE;
    end else if (fire_i) begin
      lock_q    <= lock_d;
      lock_el_q <= lock_el_d;
      rep_el_q  <= rep_el_d;
      phase_q   <= phase_d;
      level_q   <= level_d;
      pend_q    <= pend_d;
    end
  end

  assign status_o.lock_active = lock_q;
  assign status_o.pend        = pend_q;

endmodule

FILE: src/button_debounce_autorepeat.sv
// Top level of the button qualifier: input register, update core, result register.
// Depends on bda_pkg, bda_cfg, bda_in_stage and bda_core.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   in_data_i  (cmd, step_time, level)
//   out      output     out_valid_o / out_stall_i out_data_o (event_res, locked_out)
//   cfg      input      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// Each item passes from transfer into the input register, then through the update
// logic into the result register. One item per cycle is sustained while the result
// register is not stalled; the update of the timer registers per item sets that figure.
// Reset is asynchronous and active low; no clearing pass is needed.
// An output stall holds the result register and, if the input register is full,
// raises in_stall_o in the same cycle.
`timescale 1ns / 1ps

module button_debounce_autorepeat (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  bda_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output bda_pkg::out_item_t             out_data_o,
  input  logic                           cfg_we_i,
  input  logic [bda_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  bda_pkg::time_t                 cfg_wdata_i
);

  bda_pkg::cfg_t      cfg;
  bda_pkg::stage_t    stage;
  bda_pkg::out_item_t res;
  bda_pkg::status_t   status;
  logic               out_free;
  logic               fire;
  logic               out_valid_d, out_valid_q;
  bda_pkg::out_item_t out_q;

  bda_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bda_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .fire_i     (fire),
    .stage_o    (stage)
  );

  // Process the held item when the result register can take it
  assign out_free = !out_valid_q || !out_stall_i;
  assign fire     = stage.valid && out_free;

  bda_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (stage.item),
    .cfg_i    (cfg),
    .res_o    (res),
    .status_o (status)
  );

  // Result register: hold while stalled, drop after the transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // Input side stalls only behind a blocked result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  // Reported lockout flag matches the lockout state left behind
  a_lock_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (status.lock_active == out_data_o.locked_out))
    else $error("locked_out disagrees with lockout state");

  // A read leaves no latched event
  a_read_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (stage.item.cmd == bda_pkg::CMD_READ)) |=> (status.pend == bda_pkg::EV_IDLE))
    else $error("read did not clear the latched event");

  // Each processed item yields a result next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_o)
    else $error("processed item produced no result");
`endif

endmodule

FILE: test/tb.sv
// Self-checking bench for button_debounce_autorepeat: directed and random items
// against an in-bench prediction of events and lockout. Depends on bda_pkg and the RTL.
`timescale 1ns / 1ps

module tb;

  localparam int         CLK_HALF     = 10;
  localparam int         LIMIT_CYCLES = 200000;
  localparam int         HOLDOFF_LEN  = 80;
  localparam int         RAND_PHASES  = 10;
  localparam int         PHASE_ITEMS  = 140;
  localparam int         MAX_WAIT     = 14;
  localparam logic [1:0] CMD_UNUSED   = 2'd3;

  // Predict the event and lockout flag for each transfer; hold expectations in order
  class button_scoreboard;
    bda_pkg::cfg_t      regs;
    logic               lock_on;
    bda_pkg::time_t     lock_time;
    bda_pkg::time_t     hold_time;
    bda_pkg::phase_e    phase;
    logic               level_q;
    bda_pkg::event_e    pend;
    bda_pkg::out_item_t expected_events[$];
    int                 failures;

    function new();
      regs.debounce_time = bda_pkg::DEBOUNCE_RST;
      regs.repeat_delay  = bda_pkg::DELAY_RST;
      regs.repeat_period = bda_pkg::PERIOD_RST;
      lock_on   = 1'b0;
      lock_time = '0;
      hold_time = '0;
      phase     = bda_pkg::PH_RELEASED;
      level_q   = 1'b0;
      pend      = bda_pkg::EV_IDLE;
      failures  = 0;
    endfunction

    function void set_register(bda_pkg::cfg_idx_e idx, bda_pkg::time_t v);
      case (idx)
        bda_pkg::CFG_DEBOUNCE_TIME: regs.debounce_time = v;
        bda_pkg::CFG_REPEAT_DELAY:  regs.repeat_delay  = v;
        bda_pkg::CFG_REPEAT_PERIOD: regs.repeat_period = v;
        default: ;
      endcase
    endfunction

    // Clamp at all ones instead of wrapping
    function bda_pkg::time_t clamp_add(bda_pkg::time_t a, bda_pkg::time_t b);
      logic [bda_pkg::TIME_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum > {1'b0, {bda_pkg::TIME_W{1'b1}}}) clamp_add = '1;
      else clamp_add = sum[bda_pkg::TIME_W-1:0];
    endfunction

    function void latch_edge(bda_pkg::event_e ev, bda_pkg::phase_e ph);
      pend      = ev;
      phase     = ph;
      lock_on   = 1'b1;
      lock_time = '0;
      hold_time = '0;
    endfunction

    // Advance the lockout first; the tick that ends it also counts toward the hold
    function void advance_time(bda_pkg::time_t dt);
      if (lock_on) begin
        lock_time = clamp_add(lock_time, dt);
        if (lock_time >= regs.debounce_time) begin
          lock_on   = 1'b0;
          lock_time = '0;
        end
      end
      if (!lock_on && level_q &&
          ((phase == bda_pkg::PH_PRESSED && regs.repeat_delay != 0) ||
           phase == bda_pkg::PH_REPEAT))
        hold_time = clamp_add(hold_time, dt);
    endfunction

    // Ignore samples during the lockout; otherwise detect edges and repeats
    function void take_sample(logic lv);
      if (!lock_on) begin
        level_q = lv;
        if (!lv) begin
          if (phase != bda_pkg::PH_RELEASED)
            latch_edge(bda_pkg::EV_RELEASED, bda_pkg::PH_RELEASED);
        end else if (phase == bda_pkg::PH_RELEASED) begin
          latch_edge(bda_pkg::EV_PRESSED, bda_pkg::PH_PRESSED);
        end else if (phase == bda_pkg::PH_PRESSED) begin
          if (regs.repeat_delay != 0 && hold_time >= regs.repeat_delay) begin
            pend      = bda_pkg::EV_REPEAT;
            phase     = bda_pkg::PH_REPEAT;
            hold_time = '0;
          end
        end else if (hold_time >= regs.repeat_period) begin
          pend      = bda_pkg::EV_REPEAT;
          hold_time = '0;
        end
      end
    endfunction

    function void note_item(bda_pkg::in_item_t it);
      bda_pkg::out_item_t r;
      case (it.cmd)
        bda_pkg::CMD_TICK:   advance_time(it.step_time);
        bda_pkg::CMD_SAMPLE: take_sample(it.level);
        default: ;
      endcase
      r.event_res  = pend;
      r.locked_out = lock_on;
      // A read reports the event held before it clears it
      if (it.cmd == bda_pkg::CMD_READ) pend = bda_pkg::EV_IDLE;
      expected_events.push_back(r);
    endfunction

    function void check_result(bda_pkg::out_item_t got);
      bda_pkg::out_item_t want;
      if (expected_events.size() == 0) begin
        $display("%0t: result with nothing expected: event_res=%0d locked_out=%0d",
                 $time, got.event_res, got.locked_out);
        failures++;
      end else begin
        want = expected_events.pop_front();
        if (got.event_res !== want.event_res) begin
          $display("%0t: event_res expected %0d, got %0d",
                   $time, want.event_res, got.event_res);
          failures++;
        end
        if (got.locked_out !== want.locked_out) begin
          $display("%0t: locked_out expected %0d, got %0d",
                   $time, want.locked_out, got.locked_out);
          failures++;
        end
      end
    endfunction

    function int pending();
      return expected_events.size();
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  bda_pkg::in_item_t             in_data_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  bda_pkg::out_item_t            out_data_o;
  logic                          cfg_we_i;
  logic [bda_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  bda_pkg::time_t                cfg_wdata_i;

  button_scoreboard sb;
  int unsigned      cycles = 0;
  int               recv_wait = 0;
  int               holdoff_left = 0;
  logic             holdoff_req = 1'b0;
  logic             holdoff_done = 1'b0;
  logic             send_quiet = 1'b0;
  logic             recv_quiet = 1'b0;
  logic             held = 1'b0;

  button_debounce_autorepeat DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Abandon the run if it hangs
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Check each result transfer and draw the stall before the next one
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(out_data_o);
      recv_wait = recv_quiet ? 0 : $urandom_range(0, MAX_WAIT);
    end
  end

  // Drive the output stall; one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holdoff_req && !holdoff_done) begin
        holdoff_left = HOLDOFF_LEN;
        holdoff_done = 1'b1;
      end
      if (holdoff_left > 0) begin
        out_stall_i = 1'b1;
        holdoff_left--;
      end else if (recv_wait > 0) begin
        out_stall_i = 1'b1;
        recv_wait--;
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  // Offer one item after a random gap and hold it until the transfer
  task automatic send_item(logic [1:0] cmd, bda_pkg::time_t step, logic lv);
    int                gap;
    bda_pkg::in_item_t it;
    it.cmd       = cmd;
    it.step_time = step;
    it.level     = lv;
    gap = send_quiet ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      in_data_i  = bda_pkg::in_item_t'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = it;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    sb.note_item(it);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    do begin
      @(negedge clk_i);
    end while (sb.pending() != 0);
  endtask

  task automatic write_reg(bda_pkg::cfg_idx_e idx, bda_pkg::time_t v);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = v;
    @(negedge clk_i);
    sb.set_register(idx, v);
  endtask

  // Write all three registers once the block has gone idle
  task automatic load_registers(bda_pkg::time_t dbt, bda_pkg::time_t dly,
                                bda_pkg::time_t per);
    wait_drained();
    repeat (3) @(negedge clk_i);
    write_reg(bda_pkg::CFG_DEBOUNCE_TIME, dbt);
    write_reg(bda_pkg::CFG_REPEAT_DELAY, dly);
    write_reg(bda_pkg::CFG_REPEAT_PERIOD, per);
    cfg_we_i = 1'b0;
  endtask

  // Mostly steps on the scale of the current registers, with the extremes mixed in
  function automatic bda_pkg::time_t draw_step();
    int roll;
    int reach;
    reach = int'(sb.regs.debounce_time);
    if (int'(sb.regs.repeat_delay) > reach) reach = int'(sb.regs.repeat_delay);
    if (int'(sb.regs.repeat_period) > reach) reach = int'(sb.regs.repeat_period);
    reach = reach / 4 + 1;
    roll  = $urandom_range(0, 9);
    case (roll)
      0:       return '0;
      1:       return '1;
      2:       return bda_pkg::time_t'($urandom);
      default: return bda_pkg::time_t'($urandom_range(0, reach));
    endcase
  endfunction

  // Held level with occasional presses, releases and bounces
  task automatic random_items(int n);
    int         roll;
    logic [1:0] cmd;
    logic       lv;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) cmd = bda_pkg::CMD_TICK;
      else if (roll < 75) cmd = bda_pkg::CMD_SAMPLE;
      else if (roll < 95) cmd = bda_pkg::CMD_READ;
      else cmd = CMD_UNUSED;
      if ($urandom_range(0, 6) == 0) held = ~held;
      lv = ($urandom_range(0, 9) == 0) ? ~held : held;
      send_item(cmd, draw_step(), lv);
    end
  endtask

  initial begin
    sb          = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = bda_pkg::CFG_DEBOUNCE_TIME;
    cfg_wdata_i = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset registers: idle read, unused command, press, ignored bounce, overwrite
    send_item(bda_pkg::CMD_READ, 16'd0, 1'b0);
    send_item(CMD_UNUSED, '1, 1'b1);
    send_item(bda_pkg::CMD_SAMPLE, 16'd0, 1'b1);
    send_item(bda_pkg::CMD_SAMPLE, 16'd0, 1'b0);
    send_item(bda_pkg::CMD_TICK, 16'd99, 1'b0);
    send_item(bda_pkg::CMD_TICK, 16'd1, 1'b0);
    send_item(bda_pkg::CMD_SAMPLE, 16'd0, 1'b0);
    send_item(bda_pkg::CMD_READ, 16'd0, 1'b0);
    send_item(bda_pkg::CMD_TICK, '1, 1'b0);

    // Zero debounce and zero period: lockout until next tick, repeat on every sample
    load_registers(16'd0, 16'd1, 16'd0);
    send_item(bda_pkg::CMD_SAMPLE, 16'd0, 1'b1);
    send_item(bda_pkg::CMD_TICK, 16'd0, 1'b0);
    send_item(bda_pkg::CMD_SAMPLE, 16'd0, 1'b1);
    send_item(bda_pkg::CMD_TICK, '1, 1'b0);
    send_item(bda_pkg::CMD_TICK, '1, 1'b0);
    send_item(bda_pkg::CMD_SAMPLE, 16'd0, 1'b1);
    send_item(bda_pkg::CMD_READ, 16'd0, 1'b0);
    send_item(bda_pkg::CMD_SAMPLE, 16'd0, 1'b1);
    send_item(bda_pkg::CMD_SAMPLE, 16'd0, 1'b0);

    // All ones: saturating lockout, and the ending tick feeds the repeat timer
    load_registers('1, '1, '1);
    send_item(bda_pkg::CMD_TICK, '1, 1'b0);
    send_item(bda_pkg::CMD_SAMPLE, 16'd0, 1'b1);
    send_item(bda_pkg::CMD_TICK, 16'h8000, 1'b0);
    send_item(bda_pkg::CMD_TICK, '1, 1'b1);
    send_item(bda_pkg::CMD_SAMPLE, 16'd0, 1'b1);
    send_item(bda_pkg::CMD_SAMPLE, 16'd0, 1'b0);
    send_item(CMD_UNUSED, 16'h5a5a, 1'b1);

    // Random phases over several register settings
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: load_registers(16'd0, 16'd0, 16'd0);
        1: load_registers('1, '1, '1);
        2: load_registers(bda_pkg::DEBOUNCE_RST, bda_pkg::DELAY_RST, bda_pkg::PERIOD_RST);
        4: load_registers(bda_pkg::time_t'($urandom), bda_pkg::time_t'($urandom),
                          bda_pkg::time_t'($urandom));
        default: load_registers(bda_pkg::time_t'($urandom_range(0, 40)),
                                ($urandom_range(0, 3) == 0) ? bda_pkg::time_t'(0) :
                                  bda_pkg::time_t'($urandom_range(1, 80)),
                                bda_pkg::time_t'($urandom_range(0, 30)));
      endcase
      send_quiet = (p % 3 == 1);
      recv_quiet = (p % 4 == 2);
      if (p == 5) begin
        // Fill the block behind a long output hold-off, then drain mid-phase
        random_items(40);
        send_quiet  = 1'b1;
        holdoff_req = 1'b1;
        random_items(30);
        send_quiet = 1'b0;
        random_items(40);
        wait_drained();
        random_items(PHASE_ITEMS - 110);
      end else begin
        random_items(PHASE_ITEMS);
      end
    end

    wait_drained();
    repeat (8) @(negedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
